/* hdl/session_lifecycle_controller_defines.svh */
// ----------------------------------------------------------------------------
// session_lifecycle_controller_defines
// Assertion macros used by the session controller RTL.
// ----------------------------------------------------------------------------
`ifndef SESSION_LIFECYCLE_CONTROLLER_DEFINES_SVH
`define SESSION_LIFECYCLE_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SLC_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/slc_pkg.sv */
// ----------------------------------------------------------------------------
// slc_pkg
// Types and codes for the session lifecycle controller.
// ----------------------------------------------------------------------------
package slc_pkg;

   typedef enum logic [3:0] {
      PH_IDLE         = 4'd0,
      PH_CONNECTING   = 4'd1,
      PH_ASSOCIATED   = 4'd2,
      PH_DISCOVERING  = 4'd3,
      PH_DISCOVERED   = 4'd4,
      PH_SUBSCRIBING  = 4'd5,
      PH_REPORTING    = 4'd6,
      PH_RECONNECTING = 4'd7,
      PH_DEGRADED     = 4'd8,
      PH_FAILED       = 4'd9,
      PH_CLOSED       = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      REQ_QUERY    = 3'd0,
      REQ_BEGIN    = 3'd1,
      REQ_COMPLETE = 3'd2,
      REQ_REPORT   = 3'd3,
      REQ_DISCOVER = 3'd4,
      REQ_DEGRADE  = 3'd5,
      REQ_FAIL     = 3'd6,
      REQ_CLOSE    = 3'd7
   } req_kind_type;

   // op_kind codes; 5..7 carry no meaning
   localparam logic [2:0] OP_NONE      = 3'd0;
   localparam logic [2:0] OP_CONNECT   = 3'd1;
   localparam logic [2:0] OP_DISCOVER  = 3'd2;
   localparam logic [2:0] OP_SUBSCRIBE = 3'd3;
   localparam logic [2:0] OP_RECONNECT = 3'd4;

   // link flag bit positions
   localparam int LF_ASSOC = 0;
   localparam int LF_DISC  = 1;
   localparam int LF_SUBS  = 2;
   localparam int LF_REPT  = 3;

   // configuration register indexes
   localparam logic [1:0] CSR_WANT_CONNECTED    = 2'd0;
   localparam logic [1:0] CSR_WANT_DISCOVERY    = 2'd1;
   localparam logic [1:0] CSR_WANT_SUBSCRIPTION = 2'd2;
   localparam logic [1:0] CSR_WANT_REPORTING    = 2'd3;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] link;
      logic [3:0] busy;
   } sess_state_type;

   typedef struct packed {
      logic       accepted;
      logic       stale;
      logic       next_valid;
      logic [2:0] next_op;
   } step_status_type;

endpackage

/* hdl/slc_step.sv */
// ----------------------------------------------------------------------------
// slc_step
// Next-state logic for one event plus next-operation priority select.
// ----------------------------------------------------------------------------
module slc_step #(
   parameter int GEN_WIDTH = 32
) (
   input  slc_pkg::sess_state_type  cur_state,
   input  logic [GEN_WIDTH-1:0]     cur_gen,
   input  logic [3:0]               want,
   input  logic [2:0]               ev_type,
   input  logic [2:0]               ev_op,
   input  logic                     ev_ok,
   output slc_pkg::sess_state_type  nxt_state,
   output logic [GEN_WIDTH-1:0]     nxt_gen,
   output slc_pkg::step_status_type status
);

   logic [3:0] op_mask;
   logic       any_want;
   logic       ev_accepted;
   logic       ev_stale;

   function automatic logic [3:0] op_bit(input logic [2:0] op);
      logic [3:0] b;
      b = 4'b0;
      case (op)
         slc_pkg::OP_CONNECT:   b = 4'b0001;
         slc_pkg::OP_DISCOVER:  b = 4'b0010;
         slc_pkg::OP_SUBSCRIBE: b = 4'b0100;
         slc_pkg::OP_RECONNECT: b = 4'b1000;
         default:               b = 4'b0;
      endcase
      return b;
   endfunction

   assign op_mask  = op_bit(ev_op);
   assign any_want = |want;

   always_comb begin
      nxt_state   = cur_state;
      nxt_gen     = cur_gen;
      ev_accepted = 1'b0;
      ev_stale    = 1'b0;
      unique case (slc_pkg::req_kind_type'(ev_type))
         slc_pkg::REQ_QUERY: begin
         end
         slc_pkg::REQ_BEGIN: begin
            if (op_mask != 4'b0) begin
               ev_accepted = 1'b1;
               if ((cur_state.busy & op_mask) == 4'b0) begin
                  if (ev_op == slc_pkg::OP_RECONNECT) begin
                     ev_stale = 1'b1;
                     nxt_gen  = cur_gen + GEN_WIDTH'(1);
                  end else if (cur_state.phase == slc_pkg::PH_CLOSED ||
                               cur_state.phase == slc_pkg::PH_FAILED) begin
                     nxt_gen = cur_gen + GEN_WIDTH'(1);
                  end else if (ev_op == slc_pkg::OP_CONNECT &&
                               !cur_state.link[slc_pkg::LF_ASSOC]) begin
                     nxt_gen = cur_gen + GEN_WIDTH'(1);
                  end
                  nxt_state.busy = cur_state.busy | op_mask;
                  case (ev_op)
                     slc_pkg::OP_CONNECT:   nxt_state.phase = slc_pkg::PH_CONNECTING;
                     slc_pkg::OP_DISCOVER:  nxt_state.phase = slc_pkg::PH_DISCOVERING;
                     slc_pkg::OP_SUBSCRIBE: nxt_state.phase = slc_pkg::PH_SUBSCRIBING;
                     default:               nxt_state.phase = slc_pkg::PH_RECONNECTING;
                  endcase
               end
            end
         end
         slc_pkg::REQ_COMPLETE: begin
            nxt_state.busy = cur_state.busy & ~op_mask;
            if (ev_ok) begin
               case (ev_op)
                  slc_pkg::OP_CONNECT, slc_pkg::OP_RECONNECT: begin
                     nxt_state.link  = 4'b0001;
                     nxt_state.phase = slc_pkg::PH_ASSOCIATED;
                  end
                  slc_pkg::OP_DISCOVER: begin
                     nxt_state.link[slc_pkg::LF_DISC] = 1'b1;
                     nxt_state.phase                  = slc_pkg::PH_DISCOVERED;
                  end
                  slc_pkg::OP_SUBSCRIBE: begin
                     nxt_state.link[slc_pkg::LF_SUBS] = 1'b1;
                     nxt_state.link[slc_pkg::LF_REPT] = 1'b1;
                     nxt_state.phase                  = slc_pkg::PH_REPORTING;
                  end
                  default: begin
                  end
               endcase
            end else begin
               ev_stale = 1'b1;
               case (ev_op)
                  slc_pkg::OP_CONNECT: begin
                     nxt_state.link[slc_pkg::LF_ASSOC] = 1'b0;
                     nxt_state.phase                   = slc_pkg::PH_FAILED;
                  end
                  slc_pkg::OP_DISCOVER: begin
                     nxt_state.link[slc_pkg::LF_DISC] = 1'b0;
                     nxt_state.phase                  = slc_pkg::PH_DEGRADED;
                  end
                  slc_pkg::OP_SUBSCRIBE: begin
                     nxt_state.link[slc_pkg::LF_SUBS] = 1'b0;
                     nxt_state.link[slc_pkg::LF_REPT] = 1'b0;
                     nxt_state.phase                  = slc_pkg::PH_DEGRADED;
                  end
                  slc_pkg::OP_RECONNECT: begin
                     nxt_state.link  = 4'b0;
                     nxt_state.phase = slc_pkg::PH_DEGRADED;
                  end
                  default: nxt_state.phase = slc_pkg::PH_FAILED;
               endcase
            end
         end
         slc_pkg::REQ_REPORT: begin
            nxt_state.link[slc_pkg::LF_SUBS] = 1'b1;
            nxt_state.link[slc_pkg::LF_REPT] = 1'b1;
            nxt_state.phase                  = slc_pkg::PH_REPORTING;
         end
         slc_pkg::REQ_DISCOVER: begin
            nxt_state.link[slc_pkg::LF_DISC] = 1'b1;
            nxt_state.phase                  = slc_pkg::PH_DISCOVERED;
         end
         slc_pkg::REQ_DEGRADE: begin
            ev_stale        = 1'b1;
            nxt_state.phase = slc_pkg::PH_DEGRADED;
         end
         slc_pkg::REQ_FAIL: begin
            ev_stale        = 1'b1;
            nxt_state.phase = slc_pkg::PH_FAILED;
         end
         slc_pkg::REQ_CLOSE: begin
            ev_stale        = 1'b1;
            nxt_state.busy  = 4'b0;
            nxt_state.link  = 4'b0;
            nxt_state.phase = slc_pkg::PH_CLOSED;
         end
         default: begin
         end
      endcase
   end

   // next operation, fixed priority on the updated state
   always_comb begin
      status.accepted   = ev_accepted;
      status.stale      = ev_stale;
      status.next_valid = 1'b1;
      status.next_op    = slc_pkg::OP_NONE;
      if (any_want && (nxt_state.phase == slc_pkg::PH_FAILED ||
                       nxt_state.phase == slc_pkg::PH_DEGRADED ||
                       nxt_state.phase == slc_pkg::PH_CLOSED)) begin
         status.next_op = slc_pkg::OP_RECONNECT;
      end else if (!nxt_state.link[slc_pkg::LF_ASSOC] && nxt_gen != '0 && any_want) begin
         status.next_op = slc_pkg::OP_RECONNECT;
      end else if (want[slc_pkg::CSR_WANT_CONNECTED] && !nxt_state.link[slc_pkg::LF_ASSOC]) begin
         status.next_op = slc_pkg::OP_CONNECT;
      end else if (want[slc_pkg::CSR_WANT_DISCOVERY] && !nxt_state.link[slc_pkg::LF_DISC]) begin
         status.next_op = slc_pkg::OP_DISCOVER;
      end else if (want[slc_pkg::CSR_WANT_SUBSCRIPTION] &&
                   (!nxt_state.link[slc_pkg::LF_SUBS] || !nxt_state.link[slc_pkg::LF_REPT])) begin
         status.next_op = slc_pkg::OP_SUBSCRIBE;
      end else if (want[slc_pkg::CSR_WANT_REPORTING] && !nxt_state.link[slc_pkg::LF_REPT]) begin
         status.next_op = slc_pkg::OP_SUBSCRIBE;
      end else begin
         status.next_valid = 1'b0;
      end
   end

endmodule

/* hdl/session_lifecycle_controller.sv */
// ----------------------------------------------------------------------------
// session_lifecycle_controller: one event in, one status item out.
// A req passes the input register, then the result register, before rsp valid.
// Throughput 1 item per cycle unless rsp_ready stalls; session state updates as the item leaves the input register.
// Synchronous reset: phase idle, all flags, generation, stamp and want bits cleared.
// ----------------------------------------------------------------------------
`include "session_lifecycle_controller_defines.svh"

module session_lifecycle_controller #(
   parameter int GEN_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_op_kind,
   input  logic        req_op_success,
   input  logic [47:0] req_report_time,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_phase,
   output logic        rsp_is_associated,
   output logic        rsp_is_discovered,
   output logic        rsp_is_subscribed,
   output logic        rsp_is_reporting,
   output logic [3:0]  rsp_busy_mask,
   output logic [31:0] rsp_generation,
   output logic        rsp_next_valid,
   output logic [2:0]  rsp_next_op,
   output logic        rsp_accepted,
   output logic        rsp_stale_pulse,
   output logic [47:0] rsp_last_report
);

   logic [3:0]               want_ff;

   logic                     s1_valid_ff;
   logic [2:0]               s1_type_ff;
   logic [2:0]               s1_op_ff;
   logic                     s1_ok_ff;
   logic [47:0]              s1_time_ff;
   logic                     s1_fire;

   slc_pkg::sess_state_type  state_ff;
   slc_pkg::sess_state_type  state_in;
   logic [GEN_WIDTH-1:0]     gen_ff;
   logic [GEN_WIDTH-1:0]     gen_in;
   logic [47:0]              stamp_ff;
   logic [47:0]              stamp_in;
   logic [63:0]              gen_wide;
   slc_pkg::step_status_type step_status;

   logic                     rsp_valid_ff;
   slc_pkg::sess_state_type  rsp_state_ff;
   logic [31:0]              rsp_gen_ff;
   slc_pkg::step_status_type rsp_status_ff;
   logic [47:0]              rsp_stamp_ff;

   assign csr_ready = 1'b1;
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         want_ff <= 4'b0;
      end else if (csr_valid) begin
         want_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_type_ff <= req_type;
         s1_op_ff   <= req_op_kind;
         s1_ok_ff   <= req_op_success;
         s1_time_ff <= req_report_time;
      end
   end

   slc_step #(
      .GEN_WIDTH (GEN_WIDTH)
   ) u_step (
      .cur_state (state_ff),
      .cur_gen   (gen_ff),
      .want      (want_ff),
      .ev_type   (s1_type_ff),
      .ev_op     (s1_op_ff),
      .ev_ok     (s1_ok_ff),
      .nxt_state (state_in),
      .nxt_gen   (gen_in),
      .status    (step_status)
   );

   assign stamp_in = (s1_type_ff == slc_pkg::REQ_REPORT) ? s1_time_ff : stamp_ff;
   assign gen_wide = 64'(gen_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= slc_pkg::PH_IDLE;
         state_ff.link  <= 4'b0;
         state_ff.busy  <= 4'b0;
         gen_ff         <= '0;
         stamp_ff       <= 48'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (s1_fire) begin
            state_ff     <= state_in;
            gen_ff       <= gen_in;
            stamp_ff     <= stamp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_fire) begin
         rsp_state_ff  <= state_in;
         rsp_gen_ff    <= gen_wide[31:0];
         rsp_status_ff <= step_status;
         rsp_stamp_ff  <= stamp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_phase         = rsp_state_ff.phase;
   assign rsp_is_associated = rsp_state_ff.link[slc_pkg::LF_ASSOC];
   assign rsp_is_discovered = rsp_state_ff.link[slc_pkg::LF_DISC];
   assign rsp_is_subscribed = rsp_state_ff.link[slc_pkg::LF_SUBS];
   assign rsp_is_reporting  = rsp_state_ff.link[slc_pkg::LF_REPT];
   assign rsp_busy_mask     = rsp_state_ff.busy;
   assign rsp_generation    = rsp_gen_ff;
   assign rsp_next_valid    = rsp_status_ff.next_valid;
   assign rsp_next_op       = rsp_status_ff.next_op;
   assign rsp_accepted      = rsp_status_ff.accepted;
   assign rsp_stale_pulse   = rsp_status_ff.stale;
   assign rsp_last_report   = rsp_stamp_ff;

   `SLC_ASSERT_NEXT(a_gen_hold, !s1_fire, $stable(gen_ff), "generation moved without an item")
   `SLC_ASSERT(a_closed_clear, state_ff.phase == slc_pkg::PH_CLOSED, state_ff.busy == 4'b0 && state_ff.link == 4'b0, "closed session holds busy or link flags")
   `SLC_ASSERT(a_none_op, rsp_valid_ff && !rsp_status_ff.next_valid, rsp_status_ff.next_op == slc_pkg::OP_NONE, "next op set without next valid")
   `SLC_ASSERT(a_stale_begin, rsp_valid_ff && rsp_status_ff.accepted && rsp_status_ff.stale, rsp_state_ff.phase == slc_pkg::PH_RECONNECTING, "stale begin not a reconnect")

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: session lifecycle controller bench
// Drives session events and desired-state writes, predicts each status item
// from a local copy of the session state and checks every item field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 210;
   localparam logic [47:0] STAMP_MAX = '1;

   typedef struct {
      slc_pkg::req_kind_type kind;
      logic [2:0]            op;
      logic                  ok;
      logic [47:0]           stamp;
   } session_event_type;

   typedef struct {
      slc_pkg::phase_type phase;
      logic               assoc;
      logic               disc;
      logic               subs;
      logic               rept;
      logic [3:0]         busy;
      logic [31:0]        gen;
      logic               next_valid;
      logic [2:0]         next_op;
      logic               accepted;
      logic               stale;
      logic [47:0]        last_report;
   } session_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = slc_pkg::CSR_WANT_CONNECTED;
   logic        csr_wdata = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = slc_pkg::REQ_QUERY;
   logic [2:0]  req_op_kind = slc_pkg::OP_NONE;
   logic        req_op_success = 1'b0;
   logic [47:0] req_report_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_phase;
   logic        rsp_is_associated;
   logic        rsp_is_discovered;
   logic        rsp_is_subscribed;
   logic        rsp_is_reporting;
   logic [3:0]  rsp_busy_mask;
   logic [31:0] rsp_generation;
   logic        rsp_next_valid;
   logic [2:0]  rsp_next_op;
   logic        rsp_accepted;
   logic        rsp_stale_pulse;
   logic [47:0] rsp_last_report;

   session_lifecycle_controller u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_op_kind       (req_op_kind),
      .req_op_success    (req_op_success),
      .req_report_time   (req_report_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_phase         (rsp_phase),
      .rsp_is_associated (rsp_is_associated),
      .rsp_is_discovered (rsp_is_discovered),
      .rsp_is_subscribed (rsp_is_subscribed),
      .rsp_is_reporting  (rsp_is_reporting),
      .rsp_busy_mask     (rsp_busy_mask),
      .rsp_generation    (rsp_generation),
      .rsp_next_valid    (rsp_next_valid),
      .rsp_next_op       (rsp_next_op),
      .rsp_accepted      (rsp_accepted),
      .rsp_stale_pulse   (rsp_stale_pulse),
      .rsp_last_report   (rsp_last_report)
   );

   // local session state
   logic [3:0]         want_bits = '0;
   slc_pkg::phase_type sess_phase = slc_pkg::PH_IDLE;
   logic [3:0]         sess_link = '0;
   logic [3:0]         sess_busy = '0;
   logic [31:0]        sess_gen = '0;
   logic [47:0]        sess_stamp = '0;

   session_event_type  pending_events[$];
   session_status_type expected_status[$];
   session_event_type  cur_event;
   session_status_type observed;
   string              diff_text;
   logic               send_gap;
   int                 events_queued = 0;
   int                 events_taken = 0;
   int                 results_seen = 0;
   int                 fail_count = 0;
   int                 hold_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic session_status_type session_step(session_event_type ev);
      session_status_type r;
      logic [3:0] opb;
      logic any_want;
      opb = (ev.op >= slc_pkg::OP_CONNECT && ev.op <= slc_pkg::OP_RECONNECT) ?
            4'b0001 << (ev.op - 1) : 4'b0000;
      r.accepted = 1'b0;
      r.stale = 1'b0;
      case (ev.kind)
         slc_pkg::REQ_BEGIN: begin
            if (opb != 4'b0000) begin
               r.accepted = 1'b1;
               if ((sess_busy & opb) == 4'b0000) begin
                  if (ev.op == slc_pkg::OP_RECONNECT) begin
                     r.stale = 1'b1;
                     sess_gen = sess_gen + 1;
                  end else if (sess_phase == slc_pkg::PH_CLOSED ||
                               sess_phase == slc_pkg::PH_FAILED) begin
                     sess_gen = sess_gen + 1;
                  end else if (ev.op == slc_pkg::OP_CONNECT &&
                               !sess_link[slc_pkg::LF_ASSOC]) begin
                     sess_gen = sess_gen + 1;
                  end
                  sess_busy = sess_busy | opb;
                  case (ev.op)
                     slc_pkg::OP_CONNECT:   sess_phase = slc_pkg::PH_CONNECTING;
                     slc_pkg::OP_DISCOVER:  sess_phase = slc_pkg::PH_DISCOVERING;
                     slc_pkg::OP_SUBSCRIBE: sess_phase = slc_pkg::PH_SUBSCRIBING;
                     default:               sess_phase = slc_pkg::PH_RECONNECTING;
                  endcase
               end
            end
         end
         slc_pkg::REQ_COMPLETE: begin
            sess_busy = sess_busy & ~opb;
            if (ev.ok) begin
               if (ev.op == slc_pkg::OP_CONNECT || ev.op == slc_pkg::OP_RECONNECT) begin
                  sess_link = '0;
                  sess_link[slc_pkg::LF_ASSOC] = 1'b1;
                  sess_phase = slc_pkg::PH_ASSOCIATED;
               end else if (ev.op == slc_pkg::OP_DISCOVER) begin
                  sess_link[slc_pkg::LF_DISC] = 1'b1;
                  sess_phase = slc_pkg::PH_DISCOVERED;
               end else if (ev.op == slc_pkg::OP_SUBSCRIBE) begin
                  sess_link[slc_pkg::LF_SUBS] = 1'b1;
                  sess_link[slc_pkg::LF_REPT] = 1'b1;
                  sess_phase = slc_pkg::PH_REPORTING;
               end
            end else begin
               r.stale = 1'b1;
               if (ev.op == slc_pkg::OP_DISCOVER || ev.op == slc_pkg::OP_SUBSCRIBE ||
                   ev.op == slc_pkg::OP_RECONNECT)
                  sess_phase = slc_pkg::PH_DEGRADED;
               else
                  sess_phase = slc_pkg::PH_FAILED;
               case (ev.op)
                  slc_pkg::OP_CONNECT:   sess_link[slc_pkg::LF_ASSOC] = 1'b0;
                  slc_pkg::OP_DISCOVER:  sess_link[slc_pkg::LF_DISC] = 1'b0;
                  slc_pkg::OP_SUBSCRIBE: begin
                     sess_link[slc_pkg::LF_SUBS] = 1'b0;
                     sess_link[slc_pkg::LF_REPT] = 1'b0;
                  end
                  slc_pkg::OP_RECONNECT: sess_link = '0;
                  default: ;
               endcase
            end
         end
         slc_pkg::REQ_REPORT: begin
            sess_link[slc_pkg::LF_SUBS] = 1'b1;
            sess_link[slc_pkg::LF_REPT] = 1'b1;
            sess_stamp = ev.stamp;
            sess_phase = slc_pkg::PH_REPORTING;
         end
         slc_pkg::REQ_DISCOVER: begin
            sess_link[slc_pkg::LF_DISC] = 1'b1;
            sess_phase = slc_pkg::PH_DISCOVERED;
         end
         slc_pkg::REQ_DEGRADE: begin
            r.stale = 1'b1;
            sess_phase = slc_pkg::PH_DEGRADED;
         end
         slc_pkg::REQ_FAIL: begin
            r.stale = 1'b1;
            sess_phase = slc_pkg::PH_FAILED;
         end
         slc_pkg::REQ_CLOSE: begin
            r.stale = 1'b1;
            sess_busy = '0;
            sess_link = '0;
            sess_phase = slc_pkg::PH_CLOSED;
         end
         default: ;
      endcase

      // next operation by fixed priority
      any_want = |want_bits;
      r.next_valid = 1'b1;
      if (any_want && (sess_phase == slc_pkg::PH_FAILED ||
                       sess_phase == slc_pkg::PH_DEGRADED ||
                       sess_phase == slc_pkg::PH_CLOSED))
         r.next_op = slc_pkg::OP_RECONNECT;
      else if (!sess_link[slc_pkg::LF_ASSOC] && sess_gen != 0 && any_want)
         r.next_op = slc_pkg::OP_RECONNECT;
      else if (want_bits[slc_pkg::CSR_WANT_CONNECTED] && !sess_link[slc_pkg::LF_ASSOC])
         r.next_op = slc_pkg::OP_CONNECT;
      else if (want_bits[slc_pkg::CSR_WANT_DISCOVERY] && !sess_link[slc_pkg::LF_DISC])
         r.next_op = slc_pkg::OP_DISCOVER;
      else if (want_bits[slc_pkg::CSR_WANT_SUBSCRIPTION] &&
               !(sess_link[slc_pkg::LF_SUBS] && sess_link[slc_pkg::LF_REPT]))
         r.next_op = slc_pkg::OP_SUBSCRIBE;
      else if (want_bits[slc_pkg::CSR_WANT_REPORTING] && !sess_link[slc_pkg::LF_REPT])
         r.next_op = slc_pkg::OP_SUBSCRIBE;
      else begin
         r.next_valid = 1'b0;
         r.next_op = slc_pkg::OP_NONE;
      end

      r.phase = sess_phase;
      r.assoc = sess_link[slc_pkg::LF_ASSOC];
      r.disc = sess_link[slc_pkg::LF_DISC];
      r.subs = sess_link[slc_pkg::LF_SUBS];
      r.rept = sess_link[slc_pkg::LF_REPT];
      r.busy = sess_busy;
      r.gen = sess_gen;
      r.last_report = sess_stamp;
      return r;
   endfunction

   function automatic string field_diff(session_status_type e, session_status_type a);
      string s;
      s = "";
      if (a.phase !== e.phase)
         s = {s, $sformatf(" phase exp %0d got %0d", e.phase, a.phase)};
      if (a.assoc !== e.assoc)
         s = {s, $sformatf(" associated exp %0b got %0b", e.assoc, a.assoc)};
      if (a.disc !== e.disc)
         s = {s, $sformatf(" discovered exp %0b got %0b", e.disc, a.disc)};
      if (a.subs !== e.subs)
         s = {s, $sformatf(" subscribed exp %0b got %0b", e.subs, a.subs)};
      if (a.rept !== e.rept)
         s = {s, $sformatf(" reporting exp %0b got %0b", e.rept, a.rept)};
      if (a.busy !== e.busy)
         s = {s, $sformatf(" busy exp %b got %b", e.busy, a.busy)};
      if (a.gen !== e.gen)
         s = {s, $sformatf(" generation exp %0d got %0d", e.gen, a.gen)};
      if (a.next_valid !== e.next_valid)
         s = {s, $sformatf(" next_valid exp %0b got %0b", e.next_valid, a.next_valid)};
      if (a.next_op !== e.next_op)
         s = {s, $sformatf(" next_op exp %0d got %0d", e.next_op, a.next_op)};
      if (a.accepted !== e.accepted)
         s = {s, $sformatf(" accepted exp %0b got %0b", e.accepted, a.accepted)};
      if (a.stale !== e.stale)
         s = {s, $sformatf(" stale exp %0b got %0b", e.stale, a.stale)};
      if (a.last_report !== e.last_report)
         s = {s, $sformatf(" last_report exp %h got %h", e.last_report, a.last_report)};
      return s;
   endfunction

   function automatic logic [47:0] random_stamp();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return STAMP_MAX;
         default: return w[47:0];
      endcase
   endfunction

   function automatic void queue_event(slc_pkg::req_kind_type k, logic [2:0] op, logic ok,
                                       logic [47:0] stamp);
      session_event_type ev;
      ev.kind = k;
      ev.op = op;
      ev.ok = ok;
      ev.stamp = stamp;
      pending_events.push_back(ev);
      events_queued++;
   endfunction

   task automatic write_want(input logic [1:0] idx, input logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      want_bits[idx] = val;
      csr_valid <= 1'b0;
   endtask

   task automatic apply_wants(input logic [3:0] w);
      write_want(slc_pkg::CSR_WANT_CONNECTED, w[0]);
      write_want(slc_pkg::CSR_WANT_DISCOVERY, w[1]);
      write_want(slc_pkg::CSR_WANT_SUBSCRIPTION, w[2]);
      write_want(slc_pkg::CSR_WANT_REPORTING, w[3]);
   endtask

   task automatic drain_session();
      while (pending_events.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // begin/complete pairs (the largest share) with random content, some broken sequences and noise
   task automatic add_random_events();
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      op = 3'($urandom_range(1, 4));
      if (pick < 40) begin
         queue_event(slc_pkg::REQ_BEGIN, op, 1'($urandom), random_stamp());
         if ($urandom_range(0, 3) == 0)
            queue_event(slc_pkg::REQ_BEGIN, op, 1'($urandom), random_stamp());
         if ($urandom_range(0, 3) == 0)
            queue_event(slc_pkg::REQ_QUERY, 3'($urandom), 1'($urandom), random_stamp());
         if ($urandom_range(0, 4) == 0)
            queue_event(slc_pkg::REQ_REPORT, 3'($urandom), 1'($urandom), random_stamp());
         queue_event(slc_pkg::REQ_COMPLETE, op, $urandom_range(0, 99) < 85, random_stamp());
      end else if (pick < 55) begin
         queue_event(slc_pkg::REQ_REPORT, 3'($urandom), 1'($urandom), random_stamp());
      end else if (pick < 63) begin
         queue_event(slc_pkg::REQ_DISCOVER, 3'($urandom), 1'($urandom), random_stamp());
      end else if (pick < 73) begin
         queue_event(slc_pkg::REQ_QUERY, 3'($urandom), 1'($urandom), random_stamp());
      end else if (pick < 80) begin
         queue_event(slc_pkg::req_kind_type'($urandom_range(slc_pkg::REQ_DEGRADE,
                                                            slc_pkg::REQ_CLOSE)),
                     3'($urandom), 1'($urandom), random_stamp());
      end else if (pick < 88) begin
         queue_event(slc_pkg::REQ_COMPLETE, 3'($urandom), 1'($urandom), random_stamp());
      end else begin
         queue_event(slc_pkg::req_kind_type'($urandom_range(0, 7)), 3'($urandom),
                     1'($urandom), random_stamp());
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_status.push_back(session_step(cur_event));
            events_taken++;
         end
         if (!req_valid || req_ready) begin
            send_gap = !(events_taken >= 400 && events_taken < 700) &&
                       ($urandom_range(0, 99) < 21);
            if (pending_events.size() != 0 && !send_gap) begin
               cur_event = pending_events.pop_front();
               req_valid <= 1'b1;
               req_type <= cur_event.kind;
               req_op_kind <= cur_event.op;
               req_op_success <= cur_event.ok;
               req_report_time <= cur_event.stamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.phase = slc_pkg::phase_type'(rsp_phase);
            observed.assoc = rsp_is_associated;
            observed.disc = rsp_is_discovered;
            observed.subs = rsp_is_subscribed;
            observed.rept = rsp_is_reporting;
            observed.busy = rsp_busy_mask;
            observed.gen = rsp_generation;
            observed.next_valid = rsp_next_valid;
            observed.next_op = rsp_next_op;
            observed.accepted = rsp_accepted;
            observed.stale = rsp_stale_pulse;
            observed.last_report = rsp_last_report;
            if (expected_status.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("status item %0d arrived with none expected", results_seen);
            end else begin
               diff_text = field_diff(expected_status.pop_front(), observed);
               if (diff_text != "") begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("status item %0d mismatch:%s", results_seen, diff_text);
               end
            end
            results_seen++;
            // long hold-off so the block backs up into its input
            if (results_seen == 700 || results_seen == 1200)
               hold_left = 400;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (results_seen >= 400 && results_seen < 700) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= $urandom_range(0, 99) >= 21;
         end
      end
   end

   initial begin
      logic [3:0] want_plan [5];
      logic [3:0] w;
      int target;
      want_plan = '{4'b0000, 4'b0001, 4'b1010, 4'b0100, 4'b1111};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      apply_wants(4'b1111);
      queue_event(slc_pkg::REQ_QUERY, 3'd7, 1'b1, STAMP_MAX);
      queue_event(slc_pkg::REQ_COMPLETE, slc_pkg::OP_NONE, 1'b1, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_NONE, 1'b1, '0);
      queue_event(slc_pkg::REQ_BEGIN, 3'd7, 1'b0, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_CONNECT, 1'b0, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_CONNECT, 1'b1, '0);
      queue_event(slc_pkg::REQ_COMPLETE, slc_pkg::OP_CONNECT, 1'b0, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_DISCOVER, 1'b0, '0);
      queue_event(slc_pkg::REQ_COMPLETE, slc_pkg::OP_DISCOVER, 1'b0, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_RECONNECT, 1'b0, '0);
      queue_event(slc_pkg::REQ_COMPLETE, slc_pkg::OP_RECONNECT, 1'b1, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_DISCOVER, 1'b0, '0);
      queue_event(slc_pkg::REQ_DISCOVER, slc_pkg::OP_NONE, 1'b0, '0);
      queue_event(slc_pkg::REQ_COMPLETE, slc_pkg::OP_DISCOVER, 1'b1, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_SUBSCRIBE, 1'b0, '0);
      queue_event(slc_pkg::REQ_REPORT, slc_pkg::OP_NONE, 1'b0, '0);
      queue_event(slc_pkg::REQ_REPORT, slc_pkg::OP_NONE, 1'b0, STAMP_MAX);
      queue_event(slc_pkg::REQ_COMPLETE, slc_pkg::OP_SUBSCRIBE, 1'b0, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_RECONNECT, 1'b0, '0);
      queue_event(slc_pkg::REQ_COMPLETE, slc_pkg::OP_RECONNECT, 1'b0, '0);
      queue_event(slc_pkg::REQ_COMPLETE, 3'd5, 1'b0, '0);
      queue_event(slc_pkg::REQ_DEGRADE, slc_pkg::OP_NONE, 1'b0, '0);
      queue_event(slc_pkg::REQ_FAIL, slc_pkg::OP_NONE, 1'b0, '0);
      queue_event(slc_pkg::REQ_CLOSE, slc_pkg::OP_NONE, 1'b0, '0);
      queue_event(slc_pkg::REQ_BEGIN, slc_pkg::OP_SUBSCRIBE, 1'b0, '0);
      drain_session();

      for (int p = 0; p < 7; p++) begin
         w = (p < 5) ? want_plan[p] : 4'($urandom_range(0, 15));
         apply_wants(w);
         target = events_queued + PHASE_ITEMS;
         while (events_queued < target)
            add_random_events();
         drain_session();
      end

      if (fail_count == 0 && expected_status.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/slc_pkg.sv
hdl/slc_step.sv
hdl/session_lifecycle_controller.sv
bench/tb.sv
